// ----- src/terminal_key_sequence_decoder_macros.svh -----
// -----------------------------------------------------------------------------
// Terminal key sequence decoder: assertion macros
// Shared concurrent check forms, clocked on clk and disabled during reset.
// -----------------------------------------------------------------------------
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_MACROS_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TKSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TKSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tksd_pkg.sv -----
// -----------------------------------------------------------------------------
// Terminal key sequence decoder package
// Field widths, key kind codes and byte constants shared by the block.
// -----------------------------------------------------------------------------
package tksd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned VALUE_W    = 21;
  localparam int unsigned MOD_W      = 3;
  localparam int unsigned SEQ_LEN_W  = 7;
  localparam int unsigned MAX_SEQ_LEN = 75;

  localparam logic [VALUE_W-1:0] CODEPOINT_LIMIT = 21'h110000;

  localparam logic [BYTE_W-1:0] ESC_BYTE     = 8'h1B;
  localparam logic [BYTE_W-1:0] DEL_BYTE     = 8'h7F;
  localparam logic [BYTE_W-1:0] BRACKET_BYTE = 8'h5B;
  localparam logic [BYTE_W-1:0] SS3_BYTE     = 8'h4F;
  localparam logic [BYTE_W-1:0] SEMI_BYTE    = 8'h3B;
  localparam logic [BYTE_W-1:0] TILDE_BYTE   = 8'h7E;
  localparam logic [BYTE_W-1:0] BREAK_BYTE   = 8'h50;
  localparam logic [BYTE_W-1:0] DIGIT0_BYTE  = 8'h30;
  localparam logic [BYTE_W-1:0] DIGIT9_BYTE  = 8'h39;

  typedef enum logic [3:0] {
    KIND_SILENCE   = 4'd0,
    KIND_CODEPOINT = 4'd1,
    KIND_ESCAPE    = 4'd2,
    KIND_BACKSPACE = 4'd3,
    KIND_ALT       = 4'd4,
    KIND_FUNCTION  = 4'd5,
    KIND_KEYPAD    = 4'd6,
    KIND_CONSOLE   = 4'd7,
    KIND_BREAK     = 4'd8,
    KIND_INVALID   = 4'd9
  } key_kind_t;

endpackage

// ----- src/tksd_in_if.sv -----
// -----------------------------------------------------------------------------
// Terminal key sequence decoder input channel
// Valid/ready channel carrying one terminal byte or a quiet-timeout event.
// -----------------------------------------------------------------------------
interface tksd_in_if;
  import tksd_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

// ----- src/tksd_out_if.sv -----
// -----------------------------------------------------------------------------
// Terminal key sequence decoder result channel
// Valid/ready channel carrying one decoded key.
// -----------------------------------------------------------------------------
interface tksd_out_if;
  import tksd_pkg::*;

  logic               valid;
  logic               ready;
  key_kind_t          key_kind;
  logic [VALUE_W-1:0] key_value;
  logic [MOD_W-1:0]   modifier;

  modport source (output valid, output key_kind, output key_value, output modifier,
                  input ready);
  modport sink (input valid, input key_kind, input key_value, input modifier,
                output ready);
endinterface

// ----- src/terminal_key_sequence_decoder.sv -----
// -----------------------------------------------------------------------------
// Terminal key sequence decoder
// Frames terminal bytes into UTF-8, Alt and CSI/SS3 key sequences and decodes
// each finished sequence into one key result.
// -----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one beat per terminal byte (action = 0) or per quiet
//          timeout (action = 1). A timeout closes the pending sequence, or
//          gives a silence key when nothing is pending.
//   out_ch carries one beat per decoded key: kind, value and modifier.
//          Bytes that only extend a pending sequence give no beat.
//   A beat is taken into an input register; once the result register is
//   free, the beat updates the sequence state and, when the byte finishes
//   a key, loads the result register. One input beat is taken every cycle
//   while out_ch is not stalled; the rate is set by the single decode pass
//   between the input register and the result register.
//   When out_ch stalls with a result held, the input register fills and
//   in_ch.ready drops until the result is taken; nothing is lost.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parser to idle with no sequence pending.
// -----------------------------------------------------------------------------
`include "terminal_key_sequence_decoder_macros.svh"

module terminal_key_sequence_decoder (
  input  logic           clk,
  input  logic           rst_n,
  tksd_in_if.sink        in_ch,
  tksd_out_if.source     out_ch
);
  import tksd_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_UTF8 = 2'd1,
    MODE_ESC  = 2'd2
  } parse_mode_t;

  // Input register
  logic              s1_valid_r;
  logic              s1_action_r;
  logic [BYTE_W-1:0] s1_byte_r;

  // Result register
  logic               out_valid_r;
  key_kind_t          out_kind_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [MOD_W-1:0]   out_mod_r;

  // Sequence state
  parse_mode_t          mode_r, mode_nxt;
  logic [SEQ_LEN_W-1:0] seq_len_r, seq_len_nxt;
  logic [VALUE_W-1:0]   utf8_acc_r, utf8_acc_nxt;
  logic [1:0]           utf8_rem_r, utf8_rem_nxt;
  logic [BYTE_W-1:0]    second_byte_r, second_byte_nxt;
  logic                 third_brk_r, third_brk_nxt;
  logic [BYTE_W-1:0]    fourth_byte_r, fourth_byte_nxt;
  logic [BYTE_W-1:0]    final_char_r, final_char_nxt;
  logic                 final_seen_r, final_seen_nxt;
  logic [8:0]           arg_first_r, arg_first_nxt;
  logic [3:0]           arg_second_r, arg_second_nxt;
  logic [1:0]           arg_idx_r, arg_idx_nxt;

  // Decode results
  logic               emit;
  logic               finish;
  key_kind_t          res_kind;
  logic [VALUE_W-1:0] res_value;
  logic [MOD_W-1:0]   res_mod;

  // Decode temporaries
  logic [SEQ_LEN_W-1:0] len;
  logic                 is_digit;
  logic [3:0]           digit;
  logic [11:0]          prod_first;
  logic [6:0]           prod_second;
  logic [BYTE_W-1:0]    fc;
  logic [3:0]           mod_full;

  logic out_free;
  logic s1_adv;

  assign out_free = !out_valid_r || out_ch.ready;
  assign s1_adv   = s1_valid_r && out_free;

  assign in_ch.ready     = !s1_valid_r || s1_adv;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.key_kind = out_kind_r;
  assign out_ch.key_value = out_value_r;
  assign out_ch.modifier = out_mod_r;

  assign is_digit    = (s1_byte_r >= DIGIT0_BYTE) && (s1_byte_r <= DIGIT9_BYTE);
  assign digit       = s1_byte_r[3:0];
  assign prod_first  = {3'b000, arg_first_r} * 12'd10 + {8'h00, digit};
  assign prod_second = {3'b000, arg_second_r} * 7'd10 + {3'b000, digit};
  assign len         = seq_len_r + SEQ_LEN_W'(1);

  always_comb begin
    mode_nxt        = mode_r;
    seq_len_nxt     = seq_len_r;
    utf8_acc_nxt    = utf8_acc_r;
    utf8_rem_nxt    = utf8_rem_r;
    second_byte_nxt = second_byte_r;
    third_brk_nxt   = third_brk_r;
    fourth_byte_nxt = fourth_byte_r;
    final_char_nxt  = final_char_r;
    final_seen_nxt  = final_seen_r;
    arg_first_nxt   = arg_first_r;
    arg_second_nxt  = arg_second_r;
    arg_idx_nxt     = arg_idx_r;
    emit      = 1'b0;
    finish    = 1'b0;
    res_kind  = KIND_SILENCE;
    res_value = '0;
    res_mod   = '0;
    fc        = '0;
    mod_full  = '0;

    if (s1_action_r) begin
      case (mode_r)
        MODE_ESC: finish = 1'b1;
        MODE_UTF8: begin
          emit     = 1'b1;
          res_kind = KIND_INVALID;
        end
        default: begin
          emit     = 1'b1;
          res_kind = KIND_SILENCE;
        end
      endcase
    end else begin
      case (mode_r)
        MODE_ESC: begin
          if (len > SEQ_LEN_W'(MAX_SEQ_LEN)) begin
            emit     = 1'b1;
            res_kind = KIND_INVALID;
          end else begin
            seq_len_nxt = len;
            if (len == SEQ_LEN_W'(2)) begin
              second_byte_nxt = s1_byte_r;
              if (s1_byte_r != BRACKET_BYTE && s1_byte_r != SS3_BYTE) begin
                finish = 1'b1;
              end
            end else begin
              if (len == SEQ_LEN_W'(3)) begin
                third_brk_nxt = (s1_byte_r == BRACKET_BYTE);
              end
              if (len == SEQ_LEN_W'(4)) begin
                fourth_byte_nxt = s1_byte_r;
              end
              if (!final_seen_r) begin
                if (is_digit) begin
                  // Saturate arguments one past their legal maximum
                  if (arg_idx_r == 2'd0) begin
                    if (arg_first_r > 9'd256 || prod_first > 12'd256) begin
                      arg_first_nxt = 9'd257;
                    end else begin
                      arg_first_nxt = prod_first[8:0];
                    end
                  end else if (arg_idx_r == 2'd1) begin
                    if (arg_second_r > 4'd8 || prod_second > 7'd8) begin
                      arg_second_nxt = 4'd9;
                    end else begin
                      arg_second_nxt = prod_second[3:0];
                    end
                  end
                end else if (s1_byte_r == SEMI_BYTE) begin
                  if (arg_idx_r < 2'd2) begin
                    arg_idx_nxt = arg_idx_r + 2'd1;
                  end
                end else begin
                  final_seen_nxt = 1'b1;
                  final_char_nxt = s1_byte_r;
                end
              end
              if (!(s1_byte_r == BRACKET_BYTE || s1_byte_r == SEMI_BYTE || is_digit)) begin
                finish = 1'b1;
              end
            end
          end
        end
        MODE_UTF8: begin
          if (s1_byte_r[7:6] != 2'b10) begin
            emit     = 1'b1;
            res_kind = KIND_INVALID;
          end else begin
            utf8_acc_nxt = {utf8_acc_r[VALUE_W-7:0], s1_byte_r[5:0]};
            seq_len_nxt  = len;
            utf8_rem_nxt = utf8_rem_r - 2'd1;
            if (utf8_rem_nxt == 2'd0) begin
              emit = 1'b1;
              if (utf8_acc_nxt >= CODEPOINT_LIMIT) begin
                res_kind = KIND_INVALID;
              end else begin
                res_kind  = KIND_CODEPOINT;
                res_value = utf8_acc_nxt;
              end
            end
          end
        end
        default: begin
          if (s1_byte_r == ESC_BYTE) begin
            mode_nxt    = MODE_ESC;
            seq_len_nxt = SEQ_LEN_W'(1);
          end else if (s1_byte_r == DEL_BYTE) begin
            emit     = 1'b1;
            res_kind = KIND_BACKSPACE;
          end else if (!s1_byte_r[7]) begin
            emit      = 1'b1;
            res_kind  = KIND_CODEPOINT;
            res_value = VALUE_W'(s1_byte_r);
          end else if (s1_byte_r < 8'hC0 || s1_byte_r >= 8'hF8) begin
            emit     = 1'b1;
            res_kind = KIND_INVALID;
          end else begin
            mode_nxt    = MODE_UTF8;
            seq_len_nxt = SEQ_LEN_W'(1);
            if (!s1_byte_r[5]) begin
              utf8_rem_nxt = 2'd1;
              utf8_acc_nxt = VALUE_W'(s1_byte_r[4:0]);
            end else if (!s1_byte_r[4]) begin
              utf8_rem_nxt = 2'd2;
              utf8_acc_nxt = VALUE_W'(s1_byte_r[3:0]);
            end else begin
              utf8_rem_nxt = 2'd3;
              utf8_acc_nxt = VALUE_W'(s1_byte_r[2:0]);
            end
          end
        end
      endcase
    end

    // Close an escape sequence using the state as updated by this beat
    if (finish) begin
      emit     = 1'b1;
      fc       = final_seen_nxt ? final_char_nxt : '0;
      mod_full = (arg_second_nxt == 4'd0) ? 4'd0 : arg_second_nxt - 4'd1;
      if (seq_len_nxt <= SEQ_LEN_W'(1)) begin
        res_kind = KIND_ESCAPE;
      end else if (seq_len_nxt == SEQ_LEN_W'(2)) begin
        if (second_byte_nxt < DEL_BYTE) begin
          res_kind  = KIND_ALT;
          res_value = VALUE_W'(second_byte_nxt);
        end else if (second_byte_nxt == DEL_BYTE) begin
          res_kind  = KIND_CODEPOINT;
          res_value = VALUE_W'(DEL_BYTE);
        end else begin
          res_kind = KIND_INVALID;
        end
      end else if (third_brk_nxt && seq_len_nxt == SEQ_LEN_W'(4)) begin
        res_kind  = KIND_CONSOLE;
        res_value = VALUE_W'(fourth_byte_nxt);
      end else if (arg_first_nxt > 9'd256 || arg_second_nxt > 4'd8) begin
        res_kind = KIND_INVALID;
      end else if (fc == BREAK_BYTE && second_byte_nxt == BRACKET_BYTE) begin
        res_kind = KIND_BREAK;
      end else if (fc == TILDE_BYTE) begin
        res_kind  = KIND_FUNCTION;
        res_value = VALUE_W'(arg_first_nxt);
        res_mod   = mod_full[MOD_W-1:0];
      end else begin
        res_kind  = KIND_KEYPAD;
        res_value = VALUE_W'(fc);
        res_mod   = mod_full[MOD_W-1:0];
      end
    end

    // Drop the pending sequence once a key comes out
    if (emit) begin
      mode_nxt        = MODE_IDLE;
      seq_len_nxt     = '0;
      utf8_acc_nxt    = '0;
      utf8_rem_nxt    = '0;
      second_byte_nxt = '0;
      third_brk_nxt   = 1'b0;
      fourth_byte_nxt = '0;
      final_char_nxt  = '0;
      final_seen_nxt  = 1'b0;
      arg_first_nxt   = '0;
      arg_second_nxt  = '0;
      arg_idx_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      mode_r        <= MODE_IDLE;
      seq_len_r     <= '0;
      utf8_acc_r    <= '0;
      utf8_rem_r    <= '0;
      second_byte_r <= '0;
      third_brk_r   <= 1'b0;
      fourth_byte_r <= '0;
      final_char_r  <= '0;
      final_seen_r  <= 1'b0;
      arg_first_r   <= '0;
      arg_second_r  <= '0;
      arg_idx_r     <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s1_valid_r  <= 1'b1;
        s1_action_r <= in_ch.action;
        s1_byte_r   <= in_ch.data_byte;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        mode_r        <= mode_nxt;
        seq_len_r     <= seq_len_nxt;
        utf8_acc_r    <= utf8_acc_nxt;
        utf8_rem_r    <= utf8_rem_nxt;
        second_byte_r <= second_byte_nxt;
        third_brk_r   <= third_brk_nxt;
        fourth_byte_r <= fourth_byte_nxt;
        final_char_r  <= final_char_nxt;
        final_seen_r  <= final_seen_nxt;
        arg_first_r   <= arg_first_nxt;
        arg_second_r  <= arg_second_nxt;
        arg_idx_r     <= arg_idx_nxt;
        out_valid_r   <= emit;
        if (emit) begin
          out_kind_r  <= res_kind;
          out_value_r <= res_value;
          out_mod_r   <= res_mod;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `TKSD_ASSERT_NOW(a_idle_clean, mode_r == MODE_IDLE, seq_len_r == '0 && utf8_rem_r == '0, "idle parser holds a pending length or UTF-8 count")
  `TKSD_ASSERT_NOW(a_esc_len, mode_r == MODE_ESC, seq_len_r != '0 && seq_len_r <= SEQ_LEN_W'(MAX_SEQ_LEN), "escape length out of range")
  `TKSD_ASSERT_NOW(a_utf8_rem, mode_r == MODE_UTF8, utf8_rem_r != 2'd0, "UTF-8 pending with no continuation expected")
  `TKSD_ASSERT_NOW(a_mod_kind, out_valid_r && out_kind_r != KIND_FUNCTION && out_kind_r != KIND_KEYPAD, out_mod_r == '0, "modifier set on a key kind that has none")
  `TKSD_ASSERT_NOW(a_cp_range, out_valid_r && out_kind_r == KIND_CODEPOINT, out_value_r < CODEPOINT_LIMIT, "codepoint beyond the Unicode range")
  `TKSD_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_adv, s1_valid_r && $stable(s1_byte_r), "stalled input beat lost")

endmodule

// ----- tb/sv/tksd_key_checker.sv -----
// -----------------------------------------------------------------------------
// Terminal key sequence decoder checker
// Watches both channels and decodes every accepted input beat with its own
// copy of the parser state. Each result beat is compared, field by field, with
// the oldest decoded key still waiting.
// -----------------------------------------------------------------------------
module tksd_key_checker (
  input  logic clk,
  input  logic rst_n,
  tksd_in_if   in_ch,
  tksd_out_if  out_ch,
  output int   fail_count,
  output int   keys_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tksd_pkg::*;

  localparam int unsigned ARG_FIRST_MAX  = 256;
  localparam int unsigned ARG_FIRST_SAT  = 257;
  localparam int unsigned ARG_SECOND_MAX = 8;
  localparam int unsigned ARG_SECOND_SAT = 9;

  typedef enum logic [1:0] {
    PARSE_IDLE      = 2'd0,
    PARSE_MULTIBYTE = 2'd1,
    PARSE_ESC       = 2'd2
  } parse_mode_t;

  typedef struct packed {
    key_kind_t          kind;
    logic [VALUE_W-1:0] value;
    logic [MOD_W-1:0]   modifier;
  } decoded_key_t;

  parse_mode_t          parse_mode_r;
  logic [SEQ_LEN_W-1:0] seq_len_r;
  logic [VALUE_W-1:0]   utf8_acc_r;
  logic [1:0]           utf8_left_r;
  logic [BYTE_W-1:0]    second_r;
  logic                 third_bracket_r;
  logic [BYTE_W-1:0]    fourth_r;
  logic [BYTE_W-1:0]    final_r;
  logic                 final_seen_r;
  logic [8:0]           arg_first_r;
  logic [3:0]           arg_second_r;
  logic [1:0]           arg_sel_r;

  decoded_key_t expected_keys[$];

  function automatic void clear_sequence();
    parse_mode_r    = PARSE_IDLE;
    seq_len_r       = '0;
    utf8_acc_r      = '0;
    utf8_left_r     = '0;
    second_r        = '0;
    third_bracket_r = 1'b0;
    fourth_r        = '0;
    final_r         = '0;
    final_seen_r    = 1'b0;
    arg_first_r     = '0;
    arg_second_r    = '0;
    arg_sel_r       = '0;
  endfunction

  // Every finished key ends the pending sequence.
  function automatic void emit_key(key_kind_t kind, int unsigned value,
                                   int unsigned modifier);
    decoded_key_t key;
    clear_sequence();
    key.kind     = kind;
    key.value    = VALUE_W'(value);
    key.modifier = MOD_W'(modifier);
    expected_keys.push_back(key);
  endfunction

  function automatic void finish_escape_key();
    logic [BYTE_W-1:0] fc;
    int unsigned       mod;
    if (seq_len_r <= 1) begin
      emit_key(KIND_ESCAPE, 0, 0);
      return;
    end
    if (seq_len_r == 2) begin
      if (second_r < DEL_BYTE) emit_key(KIND_ALT, second_r, 0);
      else if (second_r == DEL_BYTE) emit_key(KIND_CODEPOINT, DEL_BYTE, 0);
      else emit_key(KIND_INVALID, 0, 0);
      return;
    end
    // console check wins over the argument range check
    if (third_bracket_r && seq_len_r == 4) begin
      emit_key(KIND_CONSOLE, fourth_r, 0);
      return;
    end
    fc = final_seen_r ? final_r : '0;
    if (arg_first_r > ARG_FIRST_MAX || arg_second_r > ARG_SECOND_MAX) begin
      emit_key(KIND_INVALID, 0, 0);
      return;
    end
    mod = (arg_second_r == 0) ? 0 : arg_second_r - 1;
    if (fc == BREAK_BYTE && second_r == BRACKET_BYTE) emit_key(KIND_BREAK, 0, 0);
    else if (fc == TILDE_BYTE) emit_key(KIND_FUNCTION, arg_first_r, mod);
    else emit_key(KIND_KEYPAD, fc, mod);
  endfunction

  function automatic void decode_beat(logic action, logic [BYTE_W-1:0] b);
    int unsigned len;
    int unsigned acc;
    bit          is_digit;
    is_digit = (b >= DIGIT0_BYTE) && (b <= DIGIT9_BYTE);
    if (action) begin
      case (parse_mode_r)
        PARSE_ESC:       finish_escape_key();
        PARSE_MULTIBYTE: emit_key(KIND_INVALID, 0, 0);
        default:         emit_key(KIND_SILENCE, 0, 0);
      endcase
      return;
    end
    if (parse_mode_r == PARSE_IDLE) begin
      if (b == ESC_BYTE) begin
        parse_mode_r = PARSE_ESC;
        seq_len_r    = SEQ_LEN_W'(1);
      end else if (b == DEL_BYTE) begin
        emit_key(KIND_BACKSPACE, 0, 0);
      end else if (b < 8'h80) begin
        emit_key(KIND_CODEPOINT, b, 0);
      end else if (b < 8'hC0 || b >= 8'hF8) begin
        emit_key(KIND_INVALID, 0, 0);
      end else begin
        parse_mode_r = PARSE_MULTIBYTE;
        seq_len_r    = SEQ_LEN_W'(1);
        if (b < 8'hE0) begin
          utf8_left_r = 2'd1;
          utf8_acc_r  = VALUE_W'(b[4:0]);
        end else if (b < 8'hF0) begin
          utf8_left_r = 2'd2;
          utf8_acc_r  = VALUE_W'(b[3:0]);
        end else begin
          utf8_left_r = 2'd3;
          utf8_acc_r  = VALUE_W'(b[2:0]);
        end
      end
      return;
    end
    if (parse_mode_r == PARSE_MULTIBYTE) begin
      if (b[7:6] != 2'b10) begin
        emit_key(KIND_INVALID, 0, 0);
        return;
      end
      utf8_acc_r  = {utf8_acc_r[VALUE_W-7:0], b[5:0]};
      seq_len_r   = seq_len_r + SEQ_LEN_W'(1);
      utf8_left_r = utf8_left_r - 2'd1;
      if (utf8_left_r != 0) return;
      if (utf8_acc_r >= CODEPOINT_LIMIT) emit_key(KIND_INVALID, 0, 0);
      else emit_key(KIND_CODEPOINT, utf8_acc_r, 0);
      return;
    end
    // escape sequence pending
    len = seq_len_r + 1;
    if (len > MAX_SEQ_LEN) begin
      emit_key(KIND_INVALID, 0, 0);
      return;
    end
    seq_len_r = SEQ_LEN_W'(len);
    if (len == 2) begin
      second_r = b;
      if (b != BRACKET_BYTE && b != SS3_BYTE) finish_escape_key();
      return;
    end
    if (len == 3) third_bracket_r = (b == BRACKET_BYTE);
    if (len == 4) fourth_r = b;
    if (!final_seen_r) begin
      if (is_digit) begin
        if (arg_sel_r == 0) begin
          acc = (arg_first_r > ARG_FIRST_MAX) ? ARG_FIRST_SAT :
                int'(arg_first_r) * 10 + int'(b - DIGIT0_BYTE);
          arg_first_r = 9'((acc > ARG_FIRST_MAX) ? ARG_FIRST_SAT : acc);
        end else if (arg_sel_r == 1) begin
          acc = (arg_second_r > ARG_SECOND_MAX) ? ARG_SECOND_SAT :
                int'(arg_second_r) * 10 + int'(b - DIGIT0_BYTE);
          arg_second_r = 4'((acc > ARG_SECOND_MAX) ? ARG_SECOND_SAT : acc);
        end
      end else if (b == SEMI_BYTE) begin
        if (arg_sel_r < 2) arg_sel_r = arg_sel_r + 2'd1;
      end else begin
        final_seen_r = 1'b1;
        final_r      = b;
      end
    end
    if (b == BRACKET_BYTE || b == SEMI_BYTE || is_digit) return;
    finish_escape_key();
  endfunction

  always @(posedge clk) begin
    decoded_key_t want;
    if (!rst_n) begin
      clear_sequence();
      expected_keys.delete();
      fail_count = 0;
    end else begin
      // compare first: a result never belongs to a beat taken at the same edge
      if (out_ch.valid && out_ch.ready) begin
        if (expected_keys.size() == 0) begin
          $error("unexpected key beat: key_kind %0d key_value %0h modifier %0d",
                 out_ch.key_kind, out_ch.key_value, out_ch.modifier);
          fail_count++;
        end else begin
          want = expected_keys.pop_front();
          if (out_ch.key_kind !== want.kind) begin
            $error("key_kind: expected %0d, actual %0d", want.kind, out_ch.key_kind);
            fail_count++;
          end
          if (out_ch.key_value !== want.value) begin
            $error("key_value: expected %0h, actual %0h", want.value, out_ch.key_value);
            fail_count++;
          end
          if (out_ch.modifier !== want.modifier) begin
            $error("modifier: expected %0d, actual %0d", want.modifier, out_ch.modifier);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) decode_beat(in_ch.action, in_ch.data_byte);
    end
    keys_pending = expected_keys.size();
  end

endmodule

// ----- tb/sv/tb_terminal_key_sequence_decoder.sv -----
// -----------------------------------------------------------------------------
// Terminal key sequence decoder testbench
// Sends a directed set of bytes and timeouts, then random key sequences:
// UTF-8, Alt, CSI/SS3 with random arguments, console, overlong and noise.
// Both channels idle at random; the checker predicts and compares the keys.
// -----------------------------------------------------------------------------
module tb_terminal_key_sequence_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import tksd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_GAP      = 12;
  localparam int unsigned RANDOM_BEATS = 550;
  localparam int unsigned TAIL_CYCLES  = 4;
  localparam logic        ACT_BYTE     = 1'b0;
  localparam logic        ACT_TIMEOUT  = 1'b1;

  logic        clk;
  logic        rst_n;
  bit          calm = 1'b0;
  int          fail_count;
  int          keys_pending;
  int unsigned cycle_count = 0;
  int unsigned beats_sent = 0;
  logic [8:0]  burst_q[$];

  tksd_in_if  in_ch();
  tksd_out_if out_ch();

  terminal_key_sequence_decoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tksd_key_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .keys_pending (keys_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_terminal_key_sequence_decoder failed");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic void add_byte(logic [BYTE_W-1:0] b);
    burst_q.push_back({ACT_BYTE, b});
  endfunction

  // payload rides along on a timeout and must be ignored
  function automatic void add_timeout();
    burst_q.push_back({ACT_TIMEOUT, 8'($urandom_range(0, 255))});
  endfunction

  task automatic send_burst();
    int unsigned gap;
    foreach (burst_q[i]) begin
      gap = draw_gap();
      if (gap != 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_ch.valid     = 1'b1;
      in_ch.action    = burst_q[i][8];
      in_ch.data_byte = burst_q[i][7:0];
      do @(posedge clk); while (!in_ch.ready);
      @(negedge clk);
      beats_sent++;
    end
    burst_q.delete();
  endtask

  task automatic wait_all_keys();
    in_ch.valid = 1'b0;
    while (keys_pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // result side: stall a random number of cycles before each beat
  initial begin
    int unsigned gap;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    int unsigned pick;
    int unsigned n;
    logic [7:0]  lead;
    bit          broken;
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_BYTE;
    in_ch.data_byte = '0;
    rst_n           = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: silence, ASCII, DEL, bad leads, ESC forms, CSI keys, console, top and cut UTF-8
    add_timeout();
    add_byte(8'h41);
    add_byte(8'h00);
    add_byte(DEL_BYTE);
    add_byte(8'hFF);
    add_byte(8'h80);
    add_byte(ESC_BYTE);
    add_timeout();
    add_byte(ESC_BYTE);
    add_byte(BRACKET_BYTE);
    add_timeout();
    add_byte(ESC_BYTE);
    add_byte(DEL_BYTE);
    add_byte(ESC_BYTE);
    add_byte(8'h32);
    add_byte(BRACKET_BYTE);
    add_byte(8'h32);
    add_byte(SEMI_BYTE);
    add_byte(8'h35);
    add_byte(TILDE_BYTE);
    add_byte(ESC_BYTE);
    add_byte(BRACKET_BYTE);
    add_byte(BREAK_BYTE);
    add_byte(ESC_BYTE);
    add_byte(BRACKET_BYTE);
    add_byte(BRACKET_BYTE);
    add_byte(8'h41);
    add_byte(8'hF4);
    add_byte(8'h8F);
    add_byte(8'hBF);
    add_byte(8'hBF);
    add_byte(8'hC3);
    add_timeout();
    send_burst();
    wait_all_keys();

    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      if ($urandom_range(0, 7) == 0) calm = ~calm;
      pick = $urandom_range(0, 39);
      if (pick < 2) begin
        add_timeout();
      end else if (pick < 6) begin
        add_byte(8'($urandom_range(0, 255)));
      end else if (pick < 10) begin
        add_byte(8'($urandom_range(0, 127)));
      end else if (pick < 16) begin
        // UTF-8 with random content, now and then cut short
        n    = $urandom_range(1, 3);
        lead = 8'($urandom_range(0, 255));
        case (n)
          1:       lead[7:5] = 3'b110;
          2:       lead[7:4] = 4'b1110;
          default: lead[7:3] = 5'b11110;
        endcase
        add_byte(lead);
        broken = 1'b0;
        for (int i = 0; i < n && !broken; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            broken = 1'b1;
            if ($urandom_range(0, 1) != 0) add_timeout();
            else add_byte(8'($urandom_range(0, 255)));
          end else begin
            add_byte({2'b10, 6'($urandom_range(0, 63))});
          end
        end
      end else if (pick < 20) begin
        add_byte(ESC_BYTE);
        if ($urandom_range(0, 3) == 0) add_timeout();
        else add_byte(8'($urandom_range(0, 255)));
      end else if (pick < 36) begin
        // CSI or SS3 with up to three arguments of up to three digits
        add_byte(ESC_BYTE);
        add_byte(($urandom_range(0, 1) != 0) ? BRACKET_BYTE : SS3_BYTE);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i != 0) add_byte(SEMI_BYTE);
          repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(DIGIT0_BYTE, DIGIT9_BYTE)));
        end
        case ($urandom_range(0, 7))
          0, 1, 2: add_byte(TILDE_BYTE);
          3:       add_byte(BREAK_BYTE);
          4:       add_timeout();
          5:       add_byte(8'($urandom_range(0, 255)));
          default: add_byte(8'($urandom_range(8'h41, 8'h5A)));
        endcase
      end else if (pick < 39) begin
        add_byte(ESC_BYTE);
        add_byte(($urandom_range(0, 1) != 0) ? BRACKET_BYTE : SS3_BYTE);
        add_byte(BRACKET_BYTE);
        add_byte(8'($urandom_range(0, 255)));
      end else begin
        // straddle the length limit with zero-valued arguments
        add_byte(ESC_BYTE);
        add_byte(BRACKET_BYTE);
        repeat ($urandom_range(70, 80))
          add_byte(($urandom_range(0, 3) == 0) ? SEMI_BYTE : DIGIT0_BYTE);
        add_byte(TILDE_BYTE);
      end
      send_burst();
      if ($urandom_range(0, 39) == 0) wait_all_keys();
    end

    wait_all_keys();
    if (fail_count == 0) begin
      $display("tb_terminal_key_sequence_decoder passed");
    end else begin
      $display("tb_terminal_key_sequence_decoder failed");
    end
    $finish;
  end

endmodule
